[sv/duplicate_value_zeroing_macros.svh]
// Assertion macros shared by the duplicate value zeroing RTL.
`ifndef DUPLICATE_VALUE_ZEROING_MACROS_SVH
`define DUPLICATE_VALUE_ZEROING_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DVZ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DVZ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/dvz_pkg.sv]
// Package: sizes and result type for the duplicate value zeroing block.
`timescale 1ns / 1ps
`default_nettype none
package dvz_pkg;

    // history capacity in distinct values
    localparam int MAX_DISTINCT = 256;
    localparam int ADDR_W       = (MAX_DISTINCT > 1) ? $clog2(MAX_DISTINCT) : 1;
    localparam int CNT_W        = $clog2(MAX_DISTINCT + 1);
    localparam int VALUE_W      = 32;

    // one result beat handed from the history unit to the output stage
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      dup;
        logic                      full;
    } t_dvz_res;

endpackage
`default_nettype wire

[sv/dvz_history.sv]
// History memory and scan sequencer: searches stored values, then appends.
`timescale 1ns / 1ps
`default_nettype none
module dvz_history
    import dvz_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                      i_last,
    output logic                           o_idle,
    output logic                           o_res_valid,
    input  wire logic                      i_res_ready,
    output t_dvz_res                       o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

    t_state                    r_state;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_last;
    logic [CNT_W-1:0]          r_cnt;
    logic [CNT_W-1:0]          r_idx;
    logic                      r_rd_pend;
    logic signed [VALUE_W-1:0] r_rd_data;
    t_dvz_res                  r_res;

    logic signed [VALUE_W-1:0] mem [MAX_DISTINCT];

    logic rd_en;
    logic hit_now;
    logic scan_done;
    logic has_room;
    logic wr_en;

    // read one stored value per cycle until a match or the fill count
    assign hit_now   = r_rd_pend && (r_rd_data == r_value);
    assign rd_en     = (r_state == S_SCAN) && (r_idx < r_cnt) && !hit_now;
    assign scan_done = (r_state == S_SCAN) && (hit_now || (!rd_en && !r_rd_pend));
    assign has_room  = r_cnt < CNT_W'(MAX_DISTINCT);
    assign wr_en     = scan_done && !hit_now && has_room;

    // history memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_cnt[ADDR_W-1:0]] <= r_value;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_idx[ADDR_W-1:0]];
        end
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_idx     <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_value   <= i_value;
                        r_last    <= i_last;
                        r_idx     <= '0;
                        r_rd_pend <= 1'b0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_pend <= rd_en;
                    if (rd_en) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (scan_done) begin
                        r_res.value <= hit_now ? '0 : r_value;
                        r_res.dup   <= hit_now;
                        r_res.full  <= !hit_now && !has_room;
                        // last beat closes the set
                        if (r_last) begin
                            r_cnt <= '0;
                        end else if (wr_en) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_HOLD);
    assign o_res       = r_res;

endmodule
`default_nettype wire

[sv/duplicate_value_zeroing.sv]
// Top level: zeroes values that repeat an earlier value of the same set.
// Input stream: tdata carries one signed 32-bit value, tlast closes the set.
// The history of the current set is cleared after the beat with tlast.
// Output stream: tdata carries the value, or zero if it was seen before in
// the set; tuser[0] flags a repeat, tuser[1] flags a new value that found
// the history full (it passes unchanged and is not remembered).
// One item is in the search unit at a time. The history memory is read one
// entry a cycle, and the search stops early on a match.
// The output register lets the next item be accepted and searched while a
// result still waits; if the receiver stalls longer, the finished result
// is held in the search unit and no further input is accepted.
// Reset (synchronous, active low) empties the history and drops any pending
// result; no clearing pass over the memory is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "duplicate_value_zeroing_macros.svh"
module duplicate_value_zeroing
    import dvz_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // [31:0] value_in
    input  wire logic        i_s_axis_tlast,  // last_of_set
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,  // [31:0] value_out
    output logic [1:0]       o_m_axis_tuser   // [0] was_duplicate, [1] history_full
);

    logic     hist_idle;
    logic     hist_res_valid;
    logic     hist_res_ready;
    t_dvz_res hist_res;
    logic     in_beat;

    logic     r_out_valid;
    t_dvz_res r_out;

    assign in_beat         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = hist_idle;

    dvz_history u_history (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_beat),
        .i_value     (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_idle      (hist_idle),
        .o_res_valid (hist_res_valid),
        .i_res_ready (hist_res_ready),
        .o_res       (hist_res)
    );

    // output register stage
    assign hist_res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (hist_res_ready) begin
            r_out_valid <= hist_res_valid;
            if (hist_res_valid) begin
                r_out <= hist_res;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.value;
    assign o_m_axis_tuser  = {r_out.full, r_out.dup};

    // checks
    `DVZ_ASSERT_NEXT(a_one_item_in_flight, in_beat, !o_s_axis_tready, "input accepted while busy")
    `DVZ_ASSERT_NOW(a_dup_is_zero, r_out_valid && r_out.dup, r_out.value == '0, "repeat not zeroed")
    `DVZ_ASSERT_NOW(a_dup_not_full, r_out_valid, !(r_out.dup && r_out.full), "repeat flagged full")
    `DVZ_ASSERT_NEXT(a_res_held, hist_res_valid && !hist_res_ready, hist_res_valid && $stable(hist_res),
        "pending result lost")

endmodule
`default_nettype wire

[tb/sv/dvz_checker.sv]
// Checker for duplicate_value_zeroing: tracks the set history and compares every output beat.
`timescale 1ns / 1ps
module dvz_checker
    import dvz_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // [31:0] value_in
    input  wire logic        i_s_axis_tlast,  // last_of_set
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [31:0] i_m_axis_tdata,  // [31:0] value_out
    input  wire logic [1:0]  i_m_axis_tuser,  // [0] was_duplicate, [1] history_full
    output int               o_errors,
    output int               o_outstanding,
    output int               o_results,
    output int               o_dups,
    output int               o_fulls
);

    // distinct values of the current set, in arrival order
    logic [VALUE_W-1:0] set_history [MAX_DISTINCT];
    int                 set_fill;

    // results predicted for accepted input beats, oldest first
    t_dvz_res           pending_results [$];
    t_dvz_res           want;
    int                 mismatches;
    int                 results_seen;
    int                 dup_hits;
    int                 full_hits;

    assign o_errors      = mismatches;
    assign o_outstanding = pending_results.size();
    assign o_results     = results_seen;
    assign o_dups        = dup_hits;
    assign o_fulls       = full_hits;

    // search the history, then remember the value if it is new and there is room
    function automatic t_dvz_res zero_repeats(input logic [31:0] v, input logic last);
        t_dvz_res r;
        logic     hit;
        hit = 1'b0;
        for (int i = 0; i < set_fill; i++) begin
            if (set_history[i] == v) hit = 1'b1;
        end
        r.value = hit ? '0 : v;
        r.dup   = hit;
        r.full  = 1'b0;
        if (!hit) begin
            if (set_fill < MAX_DISTINCT) begin
                set_history[set_fill] = v;
                set_fill++;
            end else begin
                r.full = 1'b1;
            end
        end
        if (last) set_fill = 0;
        return r;
    endfunction

    initial begin
        set_fill     = 0;
        mismatches   = 0;
        results_seen = 0;
        dup_hits     = 0;
        full_hits    = 0;
    end

    // predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_fill = 0;
            pending_results.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                pending_results.push_back(zero_repeats(i_s_axis_tdata, i_s_axis_tlast));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                if (i_m_axis_tuser[0]) dup_hits++;
                if (i_m_axis_tuser[1]) full_hits++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: output beat with nothing expected: value %h user %b",
                                 $realtime, i_m_axis_tdata, i_m_axis_tuser);
                end else begin
                    want = pending_results.pop_front();
                    if (want.value !== i_m_axis_tdata || want.dup !== i_m_axis_tuser[0] ||
                        want.full !== i_m_axis_tuser[1]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: beat %0d value exp %h got %h, dup exp %b got %b, full exp %b got %b",
                                     $realtime, results_seen, want.value, i_m_axis_tdata,
                                     want.dup, i_m_axis_tuser[0], want.full, i_m_axis_tuser[1]);
                    end
                end
            end
        end
    end

endmodule

[tb/sv/tb_duplicate_value_zeroing.sv]
// Testbench top for duplicate_value_zeroing: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_duplicate_value_zeroing;
    import dvz_pkg::*;

    localparam int ITEMS_TOTAL = 1950;
    localparam int HOLD_CYCLES = 800;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int          err_count;
    int          outstanding;
    int          results;
    int          dups;
    int          fulls;
    int          items_sent;
    int          sets_sent;
    int          long_sets;
    logic        quiet;

    duplicate_value_zeroing u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tlast  (s_axis_tlast),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser)
    );

    dvz_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tlast  (s_axis_tlast),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_errors        (err_count),
        .o_outstanding   (outstanding),
        .o_results       (results),
        .o_dups          (dups),
        .o_fulls         (fulls)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // hard stop well past the slowest legal run
    initial begin
        #40_000_000;
        $display("tb_duplicate_value_zeroing: errors");
        $finish;
    end

    // receiver: random stalls, one long hold-off so the block backs up
    initial begin : sink
        int  hold_left;
        bit  hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else if (!hold_done && results >= 60) begin
                hold_done     = 1'b1;
                hold_left     = HOLD_CYCLES - 1;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = quiet || ($urandom_range(99) >= 6);
            end
        end
    end

    // offer one beat, with random gaps ahead of it, and wait until it is taken
    task automatic send_beat(input logic [31:0] v, input logic last);
        quiet = (items_sent >= 700 && items_sent < 1000);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < 6) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = $urandom;
            s_axis_tlast  = 1'($urandom_range(1));
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = v;
        s_axis_tlast  = last;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        if (last) sets_sent++;
    endtask

    // 256 distinct values fill the history, then new values, repeats and zeros
    task automatic send_long_set();
        logic [31:0] stored [$];
        logic [31:0] refused [$];
        logic [31:0] v;
        int          kind;
        for (int k = 0; k < MAX_DISTINCT; k++) begin
            v = $urandom;
            stored.push_back(v);
            send_beat(v, 1'b0);
        end
        for (int j = 0; j < 24; j++) begin
            kind = $urandom_range(3);
            if (kind == 1 && refused.size() > 0)
                v = refused[$urandom_range(refused.size() - 1)];
            else if (kind == 2)
                v = stored[$urandom_range(stored.size() - 1)];
            else if (kind == 3)
                v = '0;
            else begin
                v = $urandom;
                refused.push_back(v);
            end
            send_beat(v, j == 23);
        end
    endtask

    // short set drawn mostly from a small pool, so repeats are common
    task automatic send_short_set();
        logic [31:0] pool [6];
        int          len;
        pool[0] = '0;
        pool[1] = 32'h7fff_ffff;
        pool[2] = 32'h8000_0000;
        pool[3] = 32'hffff_ffff;
        pool[4] = $urandom_range(15);
        pool[5] = $urandom;
        len = $urandom_range(1, 24);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(99) < 60)
                send_beat(pool[$urandom_range(5)], k == len - 1);
            else
                send_beat($urandom, k == len - 1);
        end
    endtask

    initial begin : stimulus
        int guard;
        items_sent    = 0;
        sets_sent     = 0;
        long_sets     = 0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // extremes, zero repeats, repeats of the most negative and positive values
        send_beat(32'h7fff_ffff, 1'b0);
        send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h0000_0000, 1'b0);
        send_beat(32'h0000_0000, 1'b0);
        send_beat(32'hffff_ffff, 1'b0);
        send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h7fff_ffff, 1'b0);
        send_beat(32'h0000_0001, 1'b0);
        send_beat(32'haaaa_aaaa, 1'b0);
        send_beat(32'h5555_5555, 1'b1);
        // history cleared: a value from the last set is new again
        send_beat(32'h7fff_ffff, 1'b1);
        // repeat on the closing beat
        send_beat(32'd5, 1'b0);
        send_beat(32'd5, 1'b1);
        send_beat(32'hffff_ffff, 1'b0);
        send_beat(32'h0000_0000, 1'b0);
        send_beat(32'h0000_0000, 1'b0);
        send_beat(32'hffff_ffff, 1'b1);
        // zero after a zeroed repeat is new unless a zero was stored
        send_beat(32'd9, 1'b0);
        send_beat(32'd9, 1'b0);
        send_beat(32'h0000_0000, 1'b0);
        send_beat(32'h0000_0000, 1'b1);

        // random sets, two of them long enough to overflow the history
        while (items_sent < ITEMS_TOTAL) begin
            if (long_sets < 2 && ((long_sets == 0 && sets_sent == 12) ||
                                  (long_sets == 1 && items_sent >= 1200))) begin
                long_sets++;
                send_long_set();
            end else begin
                send_short_set();
            end
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;

        // drain, then let a full search time pass for stray beats
        guard = 0;
        while (outstanding != 0 && guard < 50000) begin
            @(negedge clk);
            guard++;
        end
        if (outstanding != 0) begin
            $display("%0d results never arrived", outstanding);
            $display("tb_duplicate_value_zeroing: errors");
            $finish;
        end
        repeat (300) @(negedge clk);

        $display("covered %0d beats in %0d sets (%0d overflowing the history)",
                 items_sent, sets_sent, long_sets);
        $display("%0d results checked: %0d repeats zeroed, %0d new values refused, %0d mismatches",
                 results, dups, fulls, err_count);
        if (err_count == 0) begin
            $display("tb_duplicate_value_zeroing: clean");
        end else begin
            $display("tb_duplicate_value_zeroing: errors");
        end
        $finish;
    end

endmodule
